### src/tua_pkg.sv
package tua_pkg;

    // Field widths
    localparam int COORD_W    = 10;
    localparam int OFF_W      = 22;
    localparam int IDX_W      = OFF_W + 1;
    localparam int LOG2_W     = 4;
    localparam int PAGE_W     = 12;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 4;

    // 128x128 page geometry of the swizzled 4-bit layout
    localparam logic [LOG2_W-1:0]  PAGE_LOG2   = 4'd7;
    localparam logic [SHIFT_W-1:0] PAGE_ROW_SH = 5'd6;
    localparam logic [SHIFT_W-1:0] PAGE_COL_SH = 5'd8;

    typedef enum logic [1:0] {
        FMT_DIRECT = 2'd0,
        FMT_PAL8   = 2'd1,
        FMT_PAL4   = 2'd2,
        FMT_RSVD   = 2'd3
    } fmt_t;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_PIXEL_FORMAT   = 4'd0;
    localparam cfg_idx_t REG_SWIZZLE_ENABLE = 4'd1;
    localparam cfg_idx_t REG_LOG2_WIDTH     = 4'd2;
    localparam cfg_idx_t REG_LOG2_HEIGHT    = 4'd3;

    // Configuration as seen by the datapath (dimensions already clamped)
    typedef struct packed {
        fmt_t              fmt;
        logic              swz;
        logic [LOG2_W-1:0] lw;
        logic [LOG2_W-1:0] lh;
        logic [LOG2_W-1:0] hps;
        logic [LOG2_W-1:0] vps;
    } cfg_t;

    // First stage: range flag, linear index and swizzle partial terms
    typedef struct packed {
        logic               oor;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [IDX_W-1:0]   lin;
        logic [OFF_W-1:0]   col;
        logic [OFF_W-1:0]   blk8;
        logic [OFF_W-1:0]   blk4;
        logic [PAGE_W-1:0]  page;
    } stage_a_t;

    // Finished texel address
    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic             nib;
        logic             oor;
    } result_t;

endpackage

### src/tua_if.sv
interface tua_coord_if import tua_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;

    modport source (output valid, coord_x, coord_y, input ready);
    modport sink   (input valid, coord_x, coord_y, output ready);
endinterface

interface tua_addr_if import tua_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] byte_offset;
    logic             upper_nibble;
    logic             out_of_range;

    modport source (output valid, byte_offset, upper_nibble, out_of_range, input ready);
    modport sink   (input valid, byte_offset, upper_nibble, out_of_range, output ready);
endinterface

interface tua_cfg_if import tua_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/tua_cfg.sv
module tua_cfg import tua_pkg::*; #(
    parameter int MAX_LOG2_DIM = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    tua_cfg_if.sink    cfg,
    output cfg_t       cfg_q
);

    localparam logic [LOG2_W-1:0] MAX_L = LOG2_W'(MAX_LOG2_DIM);

    fmt_t              fmt_reg;
    logic              swz_reg;
    logic [LOG2_W-1:0] lw_reg;
    logic [LOG2_W-1:0] lh_reg;
    logic [LOG2_W-1:0] lw_c;
    logic [LOG2_W-1:0] lh_c;

    // Writes are always accepted
    assign cfg.ready = 1'b1;

    // Register file; unknown indices are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_PAL8;
            swz_reg <= 1'b0;
            lw_reg  <= '0;
            lh_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PIXEL_FORMAT:   fmt_reg <= fmt_t'(cfg.data[1:0]);
                REG_SWIZZLE_ENABLE: swz_reg <= cfg.data[0];
                REG_LOG2_WIDTH:     lw_reg  <= cfg.data[LOG2_W-1:0];
                REG_LOG2_HEIGHT:    lh_reg  <= cfg.data[LOG2_W-1:0];
                default:            ;
            endcase
        end
    end

    // Clamp dimensions and derive log2 page counts per row / column
    always_comb
    begin
        lw_c        = (lw_reg > MAX_L) ? MAX_L : lw_reg;
        lh_c        = (lh_reg > MAX_L) ? MAX_L : lh_reg;
        cfg_q.fmt   = fmt_reg;
        cfg_q.swz   = swz_reg;
        cfg_q.lw    = lw_c;
        cfg_q.lh    = lh_c;
        cfg_q.hps   = (lw_c > PAGE_LOG2) ? lw_c - PAGE_LOG2 : '0;
        cfg_q.vps   = (lh_c > PAGE_LOG2) ? lh_c - PAGE_LOG2 : '0;
    end

endmodule

### src/tua_front.sv
module tua_front import tua_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg_q,
    tua_coord_if.sink  coord,
    output logic       a_valid,
    input  logic       a_ready,
    output stage_a_t   a_q
);

    logic               a_valid_reg;
    stage_a_t           a_reg;
    stage_a_t           a_next;
    logic               take;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LOG2_W-1:0]  lshift;
    logic               swap;

    // Stage advances when empty or when downstream takes its item
    assign coord.ready = !a_valid_reg || a_ready;
    assign take        = coord.valid && coord.ready;
    assign a_valid     = a_valid_reg;
    assign a_q         = a_reg;

    // Range check, linear index and swizzle partial terms
    always_comb
    begin
        x      = coord.coord_x;
        y      = coord.coord_y;
        lshift = (cfg_q.fmt == FMT_PAL4) ? cfg_q.lh : cfg_q.lw;
        // bit 2 of (y + 2)
        swap   = y[2] ^ y[1];

        a_next.x    = x;
        a_next.y    = y;
        a_next.oor  = (cfg_q.fmt == FMT_RSVD) || ((x >> cfg_q.lw) != '0)
                      || ((y >> cfg_q.lh) != '0);
        a_next.lin  = (IDX_W'(y) << cfg_q.lw) + IDX_W'(x);
        // interleaved column: row pair position and rotated x
        a_next.col  = (OFF_W'({y[3], y[2], y[0], 1'b0}) << lshift)
                      + OFF_W'({x[2] ^ swap, x[1:0], 2'b00});
        // 16x16 block base for 8-bit
        a_next.blk8 = (OFF_W'({y[9:4], 4'b0000}) << cfg_q.lw)
                      + OFF_W'({x[9:4], 5'b00000});
        // 32-wide block base inside a 4-bit page
        a_next.blk4 = (OFF_W'({x[6:5], 4'b0000}) << cfg_q.lh)
                      + OFF_W'({y[6:4], 5'b00000});
        a_next.page = (PAGE_W'(y[9:7]) << cfg_q.hps) + PAGE_W'(x[9:7]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (coord.ready)
        begin
            a_valid_reg <= coord.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_reg <= a_next;
        end
    end

endmodule

### src/tua_back.sv
module tua_back import tua_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg_q,
    input  logic       a_valid,
    output logic       a_ready,
    input  stage_a_t   a_q,
    output logic       b_valid,
    input  logic       b_ready,
    output result_t    b_q
);

    logic              b_valid_reg;
    result_t           b_reg;
    result_t           b_next;
    logic [PAGE_W-1:0] pmask;
    logic [OFF_W-1:0]  pageloc;
    logic [OFF_W-1:0]  swz8;
    logic [OFF_W-1:0]  swz4;

    assign a_ready = !b_valid_reg || b_ready;
    assign b_valid = b_valid_reg;
    assign b_q     = b_reg;

    // Final sums and format select
    always_comb
    begin
        pmask   = (PAGE_W'(1) << cfg_q.vps) - PAGE_W'(1);
        pageloc = (OFF_W'(a_q.page >> cfg_q.vps) << (SHIFT_W'(cfg_q.lh) + PAGE_ROW_SH))
                  + (OFF_W'(a_q.page & pmask) << PAGE_COL_SH);
        swz8    = a_q.blk8 + a_q.col + OFF_W'({a_q.x[3], a_q.y[1]});
        swz4    = pageloc + a_q.blk4 + a_q.col + OFF_W'(a_q.x[4:3]);

        b_next.oor = a_q.oor;
        b_next.off = '0;
        b_next.nib = 1'b0;
        if (!a_q.oor)
        begin
            case (cfg_q.fmt)
                FMT_DIRECT:
                begin
                    b_next.off = {a_q.lin[OFF_W-3:0], 2'b00};
                end
                FMT_PAL8:
                begin
                    b_next.off = cfg_q.swz ? swz8 : a_q.lin[OFF_W-1:0];
                end
                FMT_PAL4:
                begin
                    b_next.off = cfg_q.swz ? swz4 : a_q.lin[IDX_W-1:1];
                    b_next.nib = cfg_q.swz ? a_q.y[1] : a_q.lin[0];
                end
                default:
                begin
                    b_next.off = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            b_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid && a_ready)
        begin
            b_reg <= b_next;
        end
    end

endmodule

### src/texture_unswizzle_address.sv
// Texel address generator for palettized and direct texture buffers.
// coord:  one transaction per texel (coord_x, coord_y); accepted on valid
//         and ready both high.
// addr:   one transaction per texel with byte_offset, upper_nibble (4-bit
//         formats) and out_of_range, in the order the coordinates came in.
// cfg:    register writes (index 0 pixel_format, 1 swizzle_enable,
//         2 log2_width, 3 log2_height); always ready, other indices are
//         dropped. Write only while no texel is in flight.
// Timing: three register stages (range and partial terms, final sums and
//         format select, output register); one texel per cycle is
//         sustained, limited only by the receiver.
// Stall:  each stage holds its item while the next one is full, so a
//         stalled receiver backs the pipe up and coord.ready falls once all
//         three stages hold data; nothing is dropped or repeated.
// Reset:  all stages empty, pixel_format 1 (8-bit index), linear layout,
//         width and height 1.
module texture_unswizzle_address import tua_pkg::*; #(
    parameter int MAX_LOG2_DIM = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    tua_cfg_if.sink      cfg,
    tua_coord_if.sink    coord,
    tua_addr_if.source   addr
);

    cfg_t     cfg_q;
    logic     a_valid;
    logic     a_ready;
    stage_a_t a_q;
    logic     b_valid;
    logic     b_ready;
    result_t  b_q;
    logic     c_valid_reg;
    result_t  c_reg;

    tua_cfg #(
        .MAX_LOG2_DIM (MAX_LOG2_DIM)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    tua_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_q   (cfg_q),
        .coord   (coord),
        .a_valid (a_valid),
        .a_ready (a_ready),
        .a_q     (a_q)
    );

    tua_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_q   (cfg_q),
        .a_valid (a_valid),
        .a_ready (a_ready),
        .a_q     (a_q),
        .b_valid (b_valid),
        .b_ready (b_ready),
        .b_q     (b_q)
    );

    // Output register
    assign b_ready = !c_valid_reg || addr.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            c_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_valid && b_ready)
        begin
            c_reg <= b_q;
        end
    end

    assign addr.valid        = c_valid_reg;
    assign addr.byte_offset  = c_reg.off;
    assign addr.upper_nibble = c_reg.nib;
    assign addr.out_of_range = c_reg.oor;

    // Out-of-range texels carry a zero address
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        addr.valid && addr.out_of_range |-> addr.byte_offset == '0 && !addr.upper_nibble)
        else $error("out-of-range texel with non-zero address");

    // Nibble select only exists in the 4-bit format
    a_nib_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        addr.valid && addr.upper_nibble |-> cfg_q.fmt == FMT_PAL4)
        else $error("upper_nibble set outside 4-bit format");

    // Reserved format code always flags the texel
    a_rsvd_oor: assert property (@(posedge clk) disable iff (!rst_n)
        addr.valid && cfg_q.fmt == FMT_RSVD |-> addr.out_of_range)
        else $error("reserved format without out_of_range");

    // Clamped dimensions never exceed the limit
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> cfg_q.lw <= LOG2_W'(MAX_LOG2_DIM) && cfg_q.lh <= LOG2_W'(MAX_LOG2_DIM))
        else $error("dimension clamp exceeded");

endmodule
